// ----- hdl/wavetable_oscillator_interp_defines.svh -----
// assertion macros shared by the wavetable oscillator modules
`ifndef WAVETABLE_OSCILLATOR_INTERP_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_INTERP_DEFINES_SVH

// condition holds at every clock edge out of reset
`define WTI_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define WTI_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define WTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/wti_pkg.sv -----
// shared types and constants of the wavetable oscillator
`timescale 1ns / 1ps

package wti_pkg;

  localparam int unsigned TableEntriesDefault = 1024;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned FracBits = 22;
  localparam int unsigned GainBits = 15;
  localparam int unsigned PhaseBits = 32;
  localparam int unsigned IncBits = 31;
  localparam int unsigned AmpBits = 16;
  localparam int unsigned ModeBits = 2;
  localparam int unsigned IndexBits = 10;
  localparam int unsigned ValueBits = 16;
  localparam int unsigned PhaseIdxBits = PhaseBits - FracBits;
  localparam int unsigned QueueDepth = 2;

  // apb register map
  localparam int unsigned AddrBits = 4;
  localparam int unsigned DataBits = 32;
  localparam int unsigned RegIdxBits = 2;
  localparam logic [RegIdxBits-1:0] RegPhaseInc = 2'd0;
  localparam logic [RegIdxBits-1:0] RegAmplitude = 2'd1;
  localparam logic [RegIdxBits-1:0] RegStartPhase = 2'd2;

  localparam logic [IncBits-1:0] PhaseIncReset = 31'd42852281;
  localparam logic [AmpBits-1:0] AmplitudeReset = 16'd16384;
  localparam logic [PhaseBits-1:0] StartPhaseReset = 32'd0;

  // request modes
  localparam logic [ModeBits-1:0] ModeTick = 2'd0;
  localparam logic [ModeBits-1:0] ModeWrite = 2'd1;
  localparam logic [ModeBits-1:0] ModeReload = 2'd2;

  typedef enum logic [1:0] {
    OpTick,
    OpWrite,
    OpReload
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic [IndexBits-1:0]        index;
    logic signed [ValueBits-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkBlend,
    BkPart,
    BkSum,
    BkOut
  } back_state_e;

endpackage

// ----- hdl/wavetable_oscillator_interp.sv -----
// top level of the wavetable oscillator with linear interpolation
// a tick passes the command queue, then holds the execution side through its steps
// (table read, blend multiply, split gain multiply, sum, round and clamp) until its
// sample is loaded, which waits while the output is stalled; table writes and reloads
// leave it idle; reset clears control state and the phase accumulator and sets
// registers to defaults; table contents are not cleared and are undefined until written
`timescale 1ns / 1ps

module wavetable_oscillator_interp #(
  parameter int unsigned TABLE_ENTRIES = wti_pkg::TableEntriesDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [wti_pkg::ModeBits-1:0]          mode_i,
  input  logic [wti_pkg::IndexBits-1:0]         table_index_i,
  input  logic signed [wti_pkg::ValueBits-1:0]  table_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [wti_pkg::SampleBits-1:0] sample_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [wti_pkg::AddrBits-1:0]          paddr,
  input  logic [wti_pkg::DataBits-1:0]          pwdata,
  output logic [wti_pkg::DataBits-1:0]          prdata,
  output logic                                  pready
);

  logic [wti_pkg::IncBits-1:0]    phase_increment_q;
  logic [wti_pkg::AmpBits-1:0]    amplitude_q;
  logic [wti_pkg::PhaseBits-1:0]  start_phase_q;
  logic [wti_pkg::RegIdxBits-1:0] reg_idx;
  logic                           reg_we;

  wti_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  assign pready = 1'b1;
  assign reg_idx = paddr[wti_pkg::AddrBits-1:2];
  assign reg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_increment_q <= wti_pkg::PhaseIncReset;
      amplitude_q <= wti_pkg::AmplitudeReset;
      start_phase_q <= wti_pkg::StartPhaseReset;
    end else if (reg_we) begin
      case (reg_idx)
        wti_pkg::RegPhaseInc:   phase_increment_q <= pwdata[wti_pkg::IncBits-1:0];
        wti_pkg::RegAmplitude:  amplitude_q <= pwdata[wti_pkg::AmpBits-1:0];
        wti_pkg::RegStartPhase: start_phase_q <= pwdata[wti_pkg::PhaseBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      wti_pkg::RegPhaseInc:   prdata = wti_pkg::DataBits'(phase_increment_q);
      wti_pkg::RegAmplitude:  prdata = wti_pkg::DataBits'(amplitude_q);
      wti_pkg::RegStartPhase: prdata = wti_pkg::DataBits'(start_phase_q);
      default:                prdata = '0;
    endcase
  end

  wti_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .cmd_o         (cmd),
    .cmd_valid_o   (cmd_valid),
    .cmd_pop_i     (cmd_pop)
  );

  wti_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cmd_valid_i       (cmd_valid),
    .cmd_pop_o         (cmd_pop),
    .phase_increment_i (phase_increment_q),
    .amplitude_i       (amplitude_q),
    .start_phase_i     (start_phase_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sample_o          (sample_o)
  );

endmodule

// ----- hdl/wti_front.sv -----
// request intake: decodes the mode and queues commands for the execution side
`timescale 1ns / 1ps
`include "wavetable_oscillator_interp_defines.svh"

module wti_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [wti_pkg::ModeBits-1:0]          mode_i,
  input  logic [wti_pkg::IndexBits-1:0]         table_index_i,
  input  logic signed [wti_pkg::ValueBits-1:0]  table_value_i,
  output wti_pkg::cmd_t                         cmd_o,
  output logic                                  cmd_valid_o,
  input  logic                                  cmd_pop_i
);

  localparam int unsigned PtrW = (wti_pkg::QueueDepth > 1) ? $clog2(wti_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(wti_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(wti_pkg::QueueDepth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(wti_pkg::QueueDepth - 1);

  wti_pkg::cmd_t   slot_q [wti_pkg::QueueDepth];
  wti_pkg::cmd_t   cmd_new;
  logic            keep;
  logic            push;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // mode 3 carries no work and is dropped here
  always_comb begin
    keep = 1'b1;
    cmd_new.op = wti_pkg::OpTick;
    cmd_new.index = table_index_i;
    cmd_new.value = table_value_i;
    case (mode_i)
      wti_pkg::ModeTick:   cmd_new.op = wti_pkg::OpTick;
      wti_pkg::ModeWrite:  cmd_new.op = wti_pkg::OpWrite;
      wti_pkg::ModeReload: cmd_new.op = wti_pkg::OpReload;
      default:             keep = 1'b0;
    endcase
  end

  assign in_stall_o = (count_q == CntFull);
  assign push = in_valid_i && !in_stall_o && keep;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !cmd_pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

  `WTI_ASSERT_ALWAYS(pop_not_empty, !(cmd_pop_i && count_q == '0),
                     "command popped from an empty queue")
  `WTI_ASSERT_ALWAYS(count_bounded, count_q <= CntFull, "queue count above depth")

endmodule

// ----- hdl/wti_back.sv -----
// execution side: table store, phase accumulator and interpolation datapath
`timescale 1ns / 1ps
`include "wavetable_oscillator_interp_defines.svh"

module wti_back #(
  parameter int unsigned TABLE_ENTRIES = wti_pkg::TableEntriesDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wti_pkg::cmd_t                         cmd_i,
  input  logic                                  cmd_valid_i,
  output logic                                  cmd_pop_o,
  input  logic [wti_pkg::IncBits-1:0]           phase_increment_i,
  input  logic [wti_pkg::AmpBits-1:0]           amplitude_i,
  input  logic [wti_pkg::PhaseBits-1:0]         start_phase_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [wti_pkg::SampleBits-1:0] sample_o
);

  localparam int unsigned AddrW = $clog2(TABLE_ENTRIES);
  localparam int unsigned ExtW = (AddrW > wti_pkg::IndexBits) ? AddrW : wti_pkg::IndexBits;
  localparam int unsigned VW = wti_pkg::ValueBits;
  localparam int unsigned FB = wti_pkg::FracBits;
  localparam int unsigned DiffW = VW + 1;
  localparam int unsigned MixW = DiffW + FB + 1;
  localparam int unsigned BlendW = VW + FB + 1;
  localparam int unsigned SplitBits = 20;
  localparam int unsigned HiW = BlendW - SplitBits;
  localparam int unsigned PartW = HiW + wti_pkg::AmpBits + 1;
  localparam int unsigned ScaledW = BlendW + wti_pkg::AmpBits + 1;
  localparam int unsigned ShiftBits = FB + wti_pkg::GainBits;
  localparam int unsigned QuoW = ScaledW - ShiftBits;
  localparam logic signed [QuoW-1:0] SatHi = QuoW'((1 << (wti_pkg::SampleBits - 1)) - 1);
  localparam logic signed [QuoW-1:0] SatLo = -SatHi - QuoW'(1);

  wti_pkg::back_state_e state_q, state_d;

  logic signed [VW-1:0]             wave_mem [TABLE_ENTRIES];
  logic signed [VW-1:0]             rd_a_q, rd_b_q;
  logic [ExtW-1:0]                  idx_ext, wr_ext;
  logic [AddrW-1:0]                 idx_a, idx_b, wr_addr;
  logic                             mem_we, mem_re;

  logic [wti_pkg::PhaseBits-1:0]    acc_q, acc_d;
  logic [FB-1:0]                    f_q;
  logic signed [DiffW-1:0]          diff;
  logic signed [MixW-1:0]           mix_prod, base;
  logic signed [BlendW-1:0]         blend_d, blend_q;
  logic signed [PartW-1:0]          ph_d, ph_q;
  logic [PartW-1:0]                 pl_d, pl_q;
  logic signed [ScaledW-1:0]        sum_d, sum_q;
  logic signed [QuoW-1:0]           quo, quo_adj;
  logic                             rem_nz;
  logic signed [wti_pkg::SampleBits-1:0] sample_d, sample_q;
  logic                             out_valid_q, out_valid_d;
  logic                             out_load;

  // table addressing, wraps at the table size
  assign idx_ext = ExtW'(acc_q[wti_pkg::PhaseBits-1:FB]);
  assign idx_a = idx_ext[AddrW-1:0];
  assign idx_b = idx_a + AddrW'(1);
  assign wr_ext = ExtW'(cmd_i.index);
  assign wr_addr = wr_ext[AddrW-1:0];

  always_comb begin
    state_d = state_q;
    cmd_pop_o = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    acc_d = acc_q;
    out_load = 1'b0;
    case (state_q)
      wti_pkg::BkIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            wti_pkg::OpTick: begin
              mem_re = 1'b1;
              acc_d = acc_q + wti_pkg::PhaseBits'(phase_increment_i);
              state_d = wti_pkg::BkBlend;
            end
            wti_pkg::OpWrite:  mem_we = 1'b1;
            wti_pkg::OpReload: acc_d = start_phase_i;
            default: ;
          endcase
        end
      end
      wti_pkg::BkBlend: state_d = wti_pkg::BkPart;
      wti_pkg::BkPart:  state_d = wti_pkg::BkSum;
      wti_pkg::BkSum:   state_d = wti_pkg::BkOut;
      wti_pkg::BkOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d = wti_pkg::BkIdle;
        end
      end
      default: state_d = wti_pkg::BkIdle;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wti_pkg::BkIdle;
      acc_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wave_mem[wr_addr] <= cmd_i.value;
    end
    if (mem_re) begin
      rd_a_q <= wave_mem[idx_a];
      rd_b_q <= wave_mem[idx_b];
    end
  end

  // blend = a * 2^22 + (b - a) * f
  always_comb begin
    diff = $signed({rd_b_q[VW-1], rd_b_q}) - $signed({rd_a_q[VW-1], rd_a_q});
    mix_prod = diff * $signed({1'b0, f_q});
    base = {{(MixW - VW - FB){rd_a_q[VW-1]}}, rd_a_q, {FB{1'b0}}};
    blend_d = BlendW'(base + mix_prod);
  end

  // gain product split into high and low partial products
  always_comb begin
    ph_d = $signed(blend_q[BlendW-1:SplitBits]) * $signed({1'b0, amplitude_i});
    pl_d = blend_q[SplitBits-1:0] * amplitude_i;
    sum_d = (ScaledW'(ph_q) <<< SplitBits) + ScaledW'(pl_q);
  end

  // truncate toward zero, then clamp
  always_comb begin
    quo = QuoW'(sum_q >>> ShiftBits);
    rem_nz = |sum_q[ShiftBits-1:0];
    quo_adj = quo + $signed({{(QuoW-1){1'b0}}, sum_q[ScaledW-1] & rem_nz});
    if (quo_adj > SatHi) begin
      sample_d = SatHi[wti_pkg::SampleBits-1:0];
    end else if (quo_adj < SatLo) begin
      sample_d = SatLo[wti_pkg::SampleBits-1:0];
    end else begin
      sample_d = quo_adj[wti_pkg::SampleBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      f_q <= acc_q[FB-1:0];
    end
    if (state_q == wti_pkg::BkBlend) begin
      blend_q <= blend_d;
    end
    if (state_q == wti_pkg::BkPart) begin
      ph_q <= ph_d;
      pl_q <= pl_d;
    end
    if (state_q == wti_pkg::BkSum) begin
      sum_q <= sum_d;
    end
    if (out_load) begin
      sample_q <= sample_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o = sample_q;

  `WTI_ASSERT_NEXT(reload_loads_acc, cmd_pop_o && cmd_i.op == wti_pkg::OpReload,
                   acc_q == $past(start_phase_i), "reload did not load the accumulator")
  `WTI_ASSERT_IMPLIES(result_from_out, $rose(out_valid_q),
                      $past(state_q) == wti_pkg::BkOut, "result raised outside output step")
  `WTI_ASSERT_NEXT(tick_starts_blend, cmd_pop_o && cmd_i.op == wti_pkg::OpTick,
                   state_q == wti_pkg::BkBlend, "tick did not enter the blend step")

endmodule
